[hdl/spurt_false_event_detector_unit_macros.svh]
// Assertion macros for the spurt false-event detector.
// Included by modules that check their own control and datapath logic.
`ifndef SPURT_FALSE_EVENT_DETECTOR_UNIT_MACROS_SVH
`define SPURT_FALSE_EVENT_DETECTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SFED_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sfed assertion failed");
`define SFED_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sfed assertion failed");
`else
`define SFED_ASSERT(lbl, prop)
`define SFED_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[hdl/sfed_pkg.sv]
// Shared types and constants of the spurt false-event detector.
// No dependencies; used by the controller, the datapath and the top level.
package sfed_pkg;

  localparam int unsigned SAMPLE_BITS_DEF     = 24;
  localparam int unsigned COUNT_BITS_DEF      = 16;
  localparam int unsigned RATIO_FRAC_BITS_DEF = 8;

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned AXIS_W    = 2;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RATIO_W   = 16;
  localparam int unsigned ENABLE_W  = 3;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [CFG_W-1:0]    PREHIST_RST = 16'd64;
  localparam logic [CFG_W-1:0]    THRESH_RST  = 16'd1280;
  localparam logic [ENABLE_W-1:0] ENABLE_RST  = 3'd7;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_NO_AXIS = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREHIST = 2'd0,
    REG_THRESH  = 2'd1,
    REG_ENABLE  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic              sample_we;
    logic              div_load;
    logic              div_step;
    logic              merge;
    logic              finish;
    logic [AXIS_W-1:0] axis;
  } sfed_cmd_t;

  typedef struct packed {
    logic                win_ok;
    logic [NUM_AXES-1:0] axis_live;
    logic                out_free;
  } sfed_sts_t;

endpackage

[hdl/spurt_false_event_detector_unit.sv]
// Spurt false-event detector, top level: configuration registers and
// controller/datapath hookup. Depends on sfed_pkg, sfed_ctrl and sfed_dp.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o): one beat per x/y/z sample
//   triple, last_sample_i marks the final beat of a window. Non-final beats
//   are taken one per cycle.
// - After the final beat the input stalls while the three axis ratios are
//   computed on one shared restoring divider, one quotient bit per cycle:
//   each enabled, non-flat axis is loaded, divided to a quotient of
//   SAMPLE_BITS+RATIO_FRAC_BITS bits and merged, a skipped axis is passed
//   over, and the result beat is loaded into the output register once it is free.
// - Output channel (out_valid_o / out_stall_i): one result beat per window,
//   held in a register. While it is stalled the next window can still be
//   collected; its result waits until the register is free.
// - Config port (cfg_valid_i / cfg_ready_o): always ready; index 0 is
//   prehistory length, 1 the 8.8 threshold, 2 the axis enable mask.
// - Reset clears the window state and loads the default configuration.
module spurt_false_event_detector_unit #(
  parameter int unsigned SAMPLE_BITS     = sfed_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS      = sfed_pkg::COUNT_BITS_DEF,
  parameter int unsigned RATIO_FRAC_BITS = sfed_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_x_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_y_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_z_i,
  input  logic                             last_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             false_event_o,
  output logic [sfed_pkg::RATIO_W-1:0]     max_ratio_o,
  output logic [sfed_pkg::STATUS_W-1:0]    status_o,
  output logic [SAMPLE_BITS-1:0]           peak_x_o,
  output logic [SAMPLE_BITS-1:0]           peak_y_o,
  output logic [SAMPLE_BITS-1:0]           peak_z_o,
  output logic [SAMPLE_BITS-1:0]           spurt_x_o,
  output logic [SAMPLE_BITS-1:0]           spurt_y_o,
  output logic [SAMPLE_BITS-1:0]           spurt_z_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sfed_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfed_pkg::CFG_W-1:0]       cfg_data_i
);
  import sfed_pkg::*;

  localparam int unsigned QUOT_BITS = SAMPLE_BITS + RATIO_FRAC_BITS;

  logic [CFG_W-1:0]    prehist_q;
  logic [CFG_W-1:0]    thresh_q;
  logic [ENABLE_W-1:0] enable_q;
  sfed_cmd_t           cmd;
  sfed_sts_t           sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prehist_q <= PREHIST_RST;
      thresh_q  <= THRESH_RST;
      enable_q  <= ENABLE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PREHIST: prehist_q <= cfg_data_i;
        REG_THRESH:  thresh_q  <= cfg_data_i;
        REG_ENABLE:  enable_q  <= cfg_data_i[ENABLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sfed_ctrl #(
    .QUOT_BITS (QUOT_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_sample_i (last_sample_i),
    .in_stall_o    (in_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  sfed_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .COUNT_BITS      (COUNT_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .sample_x_i        (sample_x_i),
    .sample_y_i        (sample_y_i),
    .sample_z_i        (sample_z_i),
    .prehistory_len_i  (prehist_q),
    .threshold_ratio_i (thresh_q),
    .axis_enable_i     (enable_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .false_event_o     (false_event_o),
    .max_ratio_o       (max_ratio_o),
    .status_o          (status_o),
    .peak_x_o          (peak_x_o),
    .peak_y_o          (peak_y_o),
    .peak_z_o          (peak_z_o),
    .spurt_x_o         (spurt_x_o),
    .spurt_y_o         (spurt_y_o),
    .spurt_z_o         (spurt_z_o)
  );

endmodule

[hdl/sfed_ctrl.sv]
// Sequencer: sample collection, per-axis division and result hand-off.
// Depends on sfed_pkg and the assertion macro header.
`include "spurt_false_event_detector_unit_macros.svh"
module sfed_ctrl #(
  parameter int unsigned QUOT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 last_sample_i,
  output logic                 in_stall_o,
  input  sfed_pkg::sfed_sts_t  sts_i,
  output sfed_pkg::sfed_cmd_t  cmd_o
);
  import sfed_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_BITS);
  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);
  localparam logic [CNT_W-1:0]  STEP_LAST = CNT_W'(QUOT_BITS - 1);

  typedef enum logic [4:0] {
    S_COLLECT = 5'b00001,
    S_LOAD    = 5'b00010,
    S_DIVIDE  = 5'b00100,
    S_MERGE   = 5'b01000,
    S_FINISH  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              accept;

  assign in_stall_o = (state_q != S_COLLECT);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_COLLECT: begin
        cmd_o.sample_we = accept;
        if (accept && last_sample_i) begin
          axis_d  = '0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.win_ok && sts_i.axis_live[axis_q]) begin
          cmd_o.div_load = 1'b1;
          cnt_d   = '0;
          state_d = S_DIVIDE;
        end else if (axis_q == AXIS_LAST) begin
          state_d = S_FINISH;
        end else begin
          axis_d = axis_q + 1'b1;
        end
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_LAST) begin
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        if (axis_q == AXIS_LAST) begin
          state_d = S_FINISH;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_COLLECT;
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
      axis_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

  `SFED_ASSERT(a_load_only_live, cmd_o.div_load |-> (sts_i.win_ok && sts_i.axis_live[axis_q]))
  `SFED_ASSERT_NEXT(a_last_starts_eval, accept && last_sample_i, state_q == S_LOAD)
  `SFED_ASSERT_NEXT(a_finish_reopens, cmd_o.finish, !in_stall_o)

endmodule

[hdl/sfed_dp.sv]
// Datapath: per-axis window statistics, shared restoring divider, result register.
// Depends on sfed_pkg and the assertion macro header.
`include "spurt_false_event_detector_unit_macros.svh"
module sfed_dp #(
  parameter int unsigned SAMPLE_BITS     = 24,
  parameter int unsigned COUNT_BITS      = 16,
  parameter int unsigned RATIO_FRAC_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sfed_pkg::sfed_cmd_t                cmd_i,
  output sfed_pkg::sfed_sts_t                sts_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_x_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_y_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_z_i,
  input  logic [sfed_pkg::CFG_W-1:0]         prehistory_len_i,
  input  logic [sfed_pkg::CFG_W-1:0]         threshold_ratio_i,
  input  logic [sfed_pkg::ENABLE_W-1:0]      axis_enable_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               false_event_o,
  output logic [sfed_pkg::RATIO_W-1:0]       max_ratio_o,
  output logic [sfed_pkg::STATUS_W-1:0]      status_o,
  output logic [SAMPLE_BITS-1:0]             peak_x_o,
  output logic [SAMPLE_BITS-1:0]             peak_y_o,
  output logic [SAMPLE_BITS-1:0]             peak_z_o,
  output logic [SAMPLE_BITS-1:0]             spurt_x_o,
  output logic [SAMPLE_BITS-1:0]             spurt_y_o,
  output logic [SAMPLE_BITS-1:0]             spurt_z_o
);
  import sfed_pkg::*;

  localparam int unsigned QUOT_BITS = SAMPLE_BITS + RATIO_FRAC_BITS;
  localparam int unsigned CMP_W     = (QUOT_BITS > RATIO_W) ? QUOT_BITS : RATIO_W;
  localparam int unsigned LEN_W     = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  logic signed [SAMPLE_BITS-1:0] min_q [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] max_q [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] prev_q [NUM_AXES];
  logic [SAMPLE_BITS-1:0]        spurt_q [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] min_d [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] max_d [NUM_AXES];
  logic [SAMPLE_BITS-1:0]        spurt_d [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] smp [NUM_AXES];
  logic [SAMPLE_BITS-1:0]        peak [NUM_AXES];
  logic [NUM_AXES-1:0]           live;
  logic signed [SAMPLE_BITS:0]   diff [NUM_AXES];
  logic signed [SAMPLE_BITS:0]   absd [NUM_AXES];
  logic [COUNT_BITS-1:0]         count_q, count_d;
  logic                          in_pre, first, win_short, no_axis, win_ok;

  logic [SAMPLE_BITS-1:0]        rem_q, rem_d;
  logic [QUOT_BITS-1:0]          quo_q, quo_d;
  logic [SAMPLE_BITS-1:0]        divisor;
  logic [SAMPLE_BITS:0]          trial;
  logic                          ge;
  logic [CMP_W-1:0]              q_ext, thr_ext;
  logic [RATIO_W-1:0]            ratio;
  logic                          hit;
  logic [RATIO_W-1:0]            maxr_q;
  logic                          fe_q;

  logic                          out_valid_q;
  logic                          fe_out_q;
  logic [RATIO_W-1:0]            maxr_out_q;
  logic [STATUS_W-1:0]           status_q;
  logic [SAMPLE_BITS-1:0]        peak_out_q [NUM_AXES];
  logic [SAMPLE_BITS-1:0]        spurt_out_q [NUM_AXES];

  assign smp[0] = sample_x_i;
  assign smp[1] = sample_y_i;
  assign smp[2] = sample_z_i;

  assign in_pre    = LEN_W'(count_q) < LEN_W'(prehistory_len_i);
  assign first     = (count_q == '0);
  assign count_d   = (count_q == '1) ? count_q : count_q + 1'b1;
  assign win_short = (prehistory_len_i == '0) || (LEN_W'(count_q) <= LEN_W'(prehistory_len_i));
  assign no_axis   = (axis_enable_i == '0);
  assign win_ok    = !win_short && !no_axis;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a]  = {smp[a][SAMPLE_BITS-1], smp[a]} - {prev_q[a][SAMPLE_BITS-1], prev_q[a]};
      absd[a]  = diff[a][SAMPLE_BITS] ? -diff[a] : diff[a];
      peak[a]  = SAMPLE_BITS'(max_q[a] - min_q[a]);
      live[a]  = axis_enable_i[a] && (max_q[a] > min_q[a]);
      min_d[a] = min_q[a];
      max_d[a] = max_q[a];
      spurt_d[a] = spurt_q[a];
      if (in_pre) begin
        if (first || smp[a] < min_q[a]) min_d[a] = smp[a];
        if (first || smp[a] > max_q[a]) max_d[a] = smp[a];
      end else if (absd[a][SAMPLE_BITS-1:0] > spurt_q[a]) begin
        spurt_d[a] = absd[a][SAMPLE_BITS-1:0];
      end
    end
  end

  always_comb begin
    case (cmd_i.axis)
      2'd0:    divisor = peak[0];
      2'd1:    divisor = peak[1];
      default: divisor = peak[2];
    endcase
  end

  assign trial   = {rem_q, quo_q[QUOT_BITS-1]};
  assign ge      = trial >= {1'b0, divisor};
  assign rem_d   = ge ? SAMPLE_BITS'(trial - {1'b0, divisor}) : trial[SAMPLE_BITS-1:0];
  assign quo_d   = {quo_q[QUOT_BITS-2:0], ge};
  assign q_ext   = CMP_W'(quo_q);
  assign thr_ext = CMP_W'(threshold_ratio_i);
  assign ratio   = (q_ext > CMP_W'(RATIO_MAX)) ? RATIO_MAX : RATIO_W'(q_ext);
  assign hit     = (q_ext > thr_ext) || ((q_ext == thr_ext) && (rem_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      maxr_q  <= '0;
      fe_q    <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        min_q[a]   <= '0;
        max_q[a]   <= '0;
        prev_q[a]  <= '0;
        spurt_q[a] <= '0;
      end
    end else if (cmd_i.finish) begin
      count_q <= '0;
      maxr_q  <= '0;
      fe_q    <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        min_q[a]   <= '0;
        max_q[a]   <= '0;
        prev_q[a]  <= '0;
        spurt_q[a] <= '0;
      end
    end else begin
      if (cmd_i.sample_we) begin
        count_q <= count_d;
        for (int a = 0; a < NUM_AXES; a++) begin
          min_q[a]   <= min_d[a];
          max_q[a]   <= max_d[a];
          prev_q[a]  <= smp[a];
          spurt_q[a] <= spurt_d[a];
        end
      end
      if (cmd_i.merge) begin
        if (ratio > maxr_q) maxr_q <= ratio;
        fe_q <= fe_q | hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      quo_q <= QUOT_BITS'(spurt_q[cmd_i.axis]) << RATIO_FRAC_BITS;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      fe_out_q   <= win_ok && fe_q;
      maxr_out_q <= win_ok ? maxr_q : '0;
      if (win_short)    status_q <= STATUS_SHORT;
      else if (no_axis) status_q <= STATUS_NO_AXIS;
      else              status_q <= STATUS_OK;
      for (int a = 0; a < NUM_AXES; a++) begin
        peak_out_q[a]  <= (win_ok && live[a]) ? peak[a] : '0;
        spurt_out_q[a] <= (win_ok && live[a]) ? spurt_q[a] : '0;
      end
    end
  end

  assign sts_o.win_ok    = win_ok;
  assign sts_o.axis_live = live;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign false_event_o = fe_out_q;
  assign max_ratio_o   = maxr_out_q;
  assign status_o      = status_q;
  assign peak_x_o      = peak_out_q[0];
  assign peak_y_o      = peak_out_q[1];
  assign peak_z_o      = peak_out_q[2];
  assign spurt_x_o     = spurt_out_q[0];
  assign spurt_y_o     = spurt_out_q[1];
  assign spurt_z_o     = spurt_out_q[2];

  `SFED_ASSERT(a_finish_slot_free, cmd_i.finish |-> !(out_valid_q && out_stall_i))
  `SFED_ASSERT_NEXT(a_rem_below_divisor, cmd_i.div_step, rem_q < divisor)

endmodule
